// ===== rtl/core/midi_byte_stream_parser_unit_assert.svh =====
// assertion macros shared by the midi byte stream parser rtl
`ifndef MIDI_BYTE_STREAM_PARSER_UNIT_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBSP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MBSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mbsp_pkg.sv =====
// types, byte codes and helpers for the midi byte stream parser
package mbsp_pkg;

    localparam int NUM_PORTS_DEF = 5;

    // midi byte codes
    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_REALTIME    = 8'hF8;
    localparam logic [7:0] BYTE_START       = 8'hFA;
    localparam logic [7:0] BYTE_CONTINUE    = 8'hFB;
    localparam logic [7:0] BYTE_STOP        = 8'hFC;

    // status high nibbles
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_AT    = 4'hA;
    localparam logic [3:0] NIB_CTRL_CHG   = 4'hB;
    localparam logic [3:0] NIB_PROG_CHG   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT    = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;

    // reported message kinds
    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_CONTINUE = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_PROG_CHG = 3'd3;
    localparam logic [2:0] KIND_CTRL_CHG = 3'd4;

    typedef struct packed {
        logic [2:0]  port;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  port_out;
        logic [2:0]  msg_kind;
        logic [4:0]  midi_channel;
        logic [6:0]  first_value;
        logic [6:0]  second_value;
        logic        first_used;
        logic        second_used;
        logic [31:0] stamp;
        logic [31:0] gap_us;
        logic        gap_valid;
    } out_item_t;

    // parser state of one port
    typedef struct packed {
        logic [7:0]  run_status;
        logic [6:0]  held_data;
        logic [1:0]  data_seen;
        logic [1:0]  data_needed;
        logic        sysex_active;
        logic [31:0] prev_stamp;
        logic        stamp_known;
    } port_state_t;

    // number of data bytes a channel status takes
    function automatic logic [1:0] length_for_status(input logic [7:0] status);
        logic [1:0] len;
        case (status[7:4]) inside
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL_CHG, NIB_PITCH_BEND:
                len = 2'd2;
            NIB_PROG_CHG, NIB_CHAN_AT:
                len = 2'd1;
            default:
                len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/mbsp_port_step.sv =====
// one byte step of a single port's parser, with result formatting
module mbsp_port_step
    import mbsp_pkg::*;
(
    input  logic [2:0]  port,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] time_us,
    input  port_state_t state_cur,
    output port_state_t state_next,
    output logic        emit,
    output out_item_t   result
);

    logic       rt_hit;
    logic [2:0] rt_kind;
    logic [1:0] seen_inc;

    // real-time byte decode
    always_comb
    begin
        rt_hit  = 1'b1;
        rt_kind = KIND_START;
        case (rx_byte)
            BYTE_START:    rt_kind = KIND_START;
            BYTE_CONTINUE: rt_kind = KIND_CONTINUE;
            BYTE_STOP:     rt_kind = KIND_STOP;
            default:       rt_hit  = 1'b0;
        endcase
    end

    assign seen_inc = state_cur.data_seen + 2'd1;

    // parser update and message assembly
    always_comb
    begin
        state_next = state_cur;
        emit       = 1'b0;
        result     = '0;
        result.port_out = port;
        result.stamp    = time_us;

        if (rx_byte >= BYTE_REALTIME)
        begin
            if (rt_hit)
            begin
                emit            = 1'b1;
                result.msg_kind = rt_kind;
            end
        end
        else if (state_cur.sysex_active)
        begin
            if (rx_byte == BYTE_SYSEX_END)
            begin
                state_next.sysex_active = 1'b0;
            end
        end
        else if (rx_byte[7])
        begin
            state_next.data_seen   = 2'd0;
            state_next.data_needed = 2'd0;
            if (rx_byte >= BYTE_SYSEX_START)
            begin
                state_next.run_status = 8'd0;
                if (rx_byte == BYTE_SYSEX_START)
                begin
                    state_next.sysex_active = 1'b1;
                end
            end
            else
            begin
                state_next.data_needed = length_for_status(rx_byte);
                state_next.run_status  = (length_for_status(rx_byte) == 2'd0) ?
                                         8'd0 : rx_byte;
            end
        end
        else if (state_cur.run_status != 8'd0 && state_cur.data_needed != 2'd0)
        begin
            if (state_cur.data_seen == 2'd0)
            begin
                state_next.held_data = rx_byte[6:0];
            end
            if (seen_inc < state_cur.data_needed)
            begin
                state_next.data_seen = seen_inc;
            end
            else
            begin
                state_next.data_seen = 2'd0;
                result.midi_channel  = {1'b0, state_cur.run_status[3:0]} + 5'd1;
                result.first_value   = state_next.held_data;
                result.first_used    = 1'b1;
                if (state_cur.run_status[7:4] == NIB_PROG_CHG)
                begin
                    emit            = 1'b1;
                    result.msg_kind = KIND_PROG_CHG;
                end
                else if (state_cur.run_status[7:4] == NIB_CTRL_CHG)
                begin
                    emit                = 1'b1;
                    result.msg_kind     = KIND_CTRL_CHG;
                    result.second_value = rx_byte[6:0];
                    result.second_used  = 1'b1;
                end
            end
        end

        // gap to this port's previous report
        if (emit)
        begin
            result.gap_valid       = state_cur.stamp_known;
            result.gap_us          = state_cur.stamp_known ?
                                     (time_us - state_cur.prev_stamp) : 32'd0;
            state_next.prev_stamp  = time_us;
            state_next.stamp_known = 1'b1;
        end
        else
        begin
            result = '0;
        end
    end

endmodule

// ===== rtl/core/midi_byte_stream_parser_unit.sv =====
// top level of the midi byte stream parser with per-port running status
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data  (port, rx_byte, time_us)
//  out     | output    | out_valid / out_ready  | out_data (one per KIND_* message)
//
// one byte per cycle while the output register is not stalled; a byte is captured
// in the input register and its report is then registered in the output register
// the per-port parser state lives in flip-flops and is updated as the byte
// leaves the input register, so back-to-back bytes on one port see fresh state
// rst_n clears all parser state, stamps and both valid flags at once
// a stalled output register holds the input register, then in_ready drops
module midi_byte_stream_parser_unit
    import mbsp_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic        in_valid_reg;
    logic        in_valid_next;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;

    port_state_t state_reg [NUM_PORTS];
    port_state_t state_cur;
    port_state_t state_next;

    logic [4:0]            port_ext;
    logic [PORT_IDX_W-1:0] port_idx;
    logic                  port_ok;
    logic                  advance;
    logic                  step_emit;
    out_item_t             step_result;

    // port decode
    assign port_ext = {2'b00, in_data_reg.port};
    assign port_idx = port_ext[PORT_IDX_W-1:0];
    assign port_ok  = (port_ext < 5'(NUM_PORTS));

    always_comb
    begin
        state_cur = '0;
        if (port_ok)
        begin
            state_cur = state_reg[port_idx];
        end
    end

    mbsp_port_step u_step (
        .port       (in_data_reg.port),
        .rx_byte    (in_data_reg.rx_byte),
        .time_us    (in_data_reg.time_us),
        .state_cur  (state_cur),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && port_ok && step_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance && port_ok && step_emit)
        begin
            out_data_reg <= step_result;
        end
    end

    // per-port parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (advance && port_ok)
        begin
            state_reg[port_idx] <= state_next;
        end
    end

    `include "midi_byte_stream_parser_unit_assert.svh"

    `MBSP_ASSERT_IMPLY(a_rt_no_channel, out_valid_reg && out_data_reg.msg_kind <= KIND_STOP, out_data_reg.midi_channel == 5'd0 && !out_data_reg.first_used, "real-time report carries channel data")
    `MBSP_ASSERT_IMPLY(a_chan_range, out_valid_reg && out_data_reg.msg_kind >= KIND_PROG_CHG, out_data_reg.midi_channel != 5'd0 && out_data_reg.first_used, "channel report without channel")
    `MBSP_ASSERT_IMPLY(a_gap_zero, out_valid_reg && !out_data_reg.gap_valid, out_data_reg.gap_us == 32'd0, "gap set without earlier report")
    `MBSP_ASSERT_IMPLY(a_port_range, out_valid_reg, 5'(out_data_reg.port_out) < 5'(NUM_PORTS), "report for a port out of range")
    `MBSP_ASSERT_IMPLY(a_free_ready, !out_valid_reg, in_ready, "input stalled with free output register")
    `MBSP_ASSERT_NEXT(a_report_next, advance && port_ok && step_emit, out_valid_reg, "report lost on its way out")

endmodule
